/* rtl/core/pwks_pkg.sv */
// shared types and constants for the packed word key search
package pwks_pkg;

  localparam int BUS_BITS     = 64;
  localparam int KEY_W        = 32;
  localparam int MAX_KEY_BITS = 32;
  localparam int CFG_DATA_W   = 6;
  localparam int CFG_INDEX_W  = 2;
  localparam int MODE_W       = 2;
  localparam int POS_W        = 6;
  localparam int RCP_SHIFT    = 13;
  localparam int RCP_W        = RCP_SHIFT + 1;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_BITS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PACK_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCATE_MODE = 2'd2;

  localparam logic [MODE_W-1:0] MODE_LOW_TOP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HIGH_TOP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOW_BOTTOM = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
  } ctl_t;

endpackage

/* rtl/core/pwks_slot_prep.sv */
// first stage: slot patterns, key replication and xor with the bucket word
module pwks_slot_prep #(
  parameter int WORD_BITS = 64,
  parameter int NMAX      = 32,
  parameter int IDX_W     = 5
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [WORD_BITS-1:0]                  bucket,
  input  logic [pwks_pkg::KEY_W-1:0]            search_key,
  input  logic [pwks_pkg::CFG_DATA_W-1:0]       key_bits,
  input  logic                                  pack_low,
  input  logic [pwks_pkg::MODE_W-1:0]           locate_mode,
  output pwks_pkg::ctl_t                        ctl,
  output logic [IDX_W-1:0]                      n_idx,
  output logic [WORD_BITS-1:0]                  x,
  output logic [WORD_BITS-1:0]                  lsbs,
  output logic [WORD_BITS-1:0]                  msbs
);

  logic [pwks_pkg::CFG_DATA_W-1:0] n;
  logic [IDX_W-1:0]                idx;
  logic [pwks_pkg::KEY_W-1:0]      km;
  logic [WORD_BITS-1:0]            lsb_hi_tab [NMAX];
  logic [WORD_BITS-1:0]            lsb_lo_tab [NMAX];
  logic [WORD_BITS-1:0]            msb_hi_tab [NMAX];
  logic [WORD_BITS-1:0]            msb_lo_tab [NMAX];
  logic [WORD_BITS-1:0]            key_hi_tab [NMAX];
  logic [WORD_BITS-1:0]            key_lo_tab [NMAX];
  logic [WORD_BITS-1:0]            keys;

  // effective slot width, clamped to 1..NMAX
  always_comb begin
    if (key_bits == '0) begin
      n = pwks_pkg::CFG_DATA_W'(1);
    end else if (key_bits > pwks_pkg::CFG_DATA_W'(NMAX)) begin
      n = pwks_pkg::CFG_DATA_W'(NMAX);
    end else begin
      n = key_bits;
    end
    idx = IDX_W'(n - pwks_pkg::CFG_DATA_W'(1));
  end

  always_comb begin
    for (int j = 0; j < pwks_pkg::KEY_W; j++) begin
      km[j] = search_key[j] & (pwks_pkg::CFG_DATA_W'(j) < n);
    end
  end

  for (genvar g = 1; g <= NMAX; g++) begin : g_width
    localparam int Rem = WORD_BITS % g;
    for (genvar i = 0; i < WORD_BITS; i++) begin : g_bit
      localparam bit InHi   = (i >= Rem);
      localparam bit InLo   = (i < WORD_BITS - Rem);
      localparam int OffHi  = InHi ? ((i - Rem) % g) : 0;
      localparam int OffLo  = i % g;
      localparam bit LsbHi  = InHi && (OffHi == 0);
      localparam bit MsbHi  = InHi && (OffHi == g - 1);
      localparam bit LsbLo  = InLo && (OffLo == 0);
      localparam bit MsbLo  = InLo && (OffLo == g - 1);
      assign lsb_hi_tab[g-1][i] = LsbHi;
      assign msb_hi_tab[g-1][i] = MsbHi;
      assign lsb_lo_tab[g-1][i] = LsbLo;
      assign msb_lo_tab[g-1][i] = MsbLo;
      assign key_hi_tab[g-1][i] = InHi ? km[OffHi] : 1'b0;
      assign key_lo_tab[g-1][i] = InLo ? km[OffLo] : 1'b0;
    end
  end

  assign keys = pack_low ? key_lo_tab[idx] : key_hi_tab[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= in_valid;
      ctl.mode  <= locate_mode;
    end
  end

  always_ff @(posedge clk) begin
    n_idx <= idx;
    x     <= keys ^ bucket;
    lsbs  <= pack_low ? lsb_lo_tab[idx] : lsb_hi_tab[idx];
    msbs  <= pack_low ? msb_lo_tab[idx] : msb_hi_tab[idx];
  end

endmodule

/* rtl/core/pwks_match.sv */
// second stage: subtract, not and mask test over all slots
module pwks_match #(
  parameter int WORD_BITS = 64,
  parameter int IDX_W     = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pwks_pkg::ctl_t       ctl_in,
  input  logic [IDX_W-1:0]     n_idx_in,
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] lsbs,
  input  logic [WORD_BITS-1:0] msbs,
  output pwks_pkg::ctl_t       ctl,
  output logic [IDX_W-1:0]     n_idx,
  output logic [WORD_BITS-1:0] magic
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    n_idx <= n_idx_in;
    magic <= (x - lsbs) & ~x & msbs;
  end

endmodule

/* rtl/core/pwks_locate.sv */
// third and fourth stages: bit search, then slot index by reciprocal multiply
module pwks_locate #(
  parameter int WORD_BITS = 64,
  parameter int NMAX      = 32,
  parameter int IDX_W     = 5,
  parameter int BIT_W     = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pwks_pkg::ctl_t                ctl_in,
  input  logic [IDX_W-1:0]              n_idx_in,
  input  logic [WORD_BITS-1:0]          magic_in,
  output logic                          done,
  output logic [WORD_BITS-1:0]          magic,
  output logic                          found,
  output logic [pwks_pkg::POS_W-1:0]    slot_position
);

  localparam int PROD_W = pwks_pkg::RCP_SHIFT + pwks_pkg::POS_W;
  localparam logic [BIT_W-1:0] TOP = BIT_W'(WORD_BITS - 1);

  logic [BIT_W-1:0]          lo_bit;
  logic [BIT_W-1:0]          hi_bit;
  logic [BIT_W-1:0]          numer_next;
  logic                      valid3;
  logic [pwks_pkg::MODE_W-1:0] mode3;
  logic [IDX_W-1:0]          n_idx3;
  logic [BIT_W-1:0]          numer;
  logic                      found3;
  logic                      use_pos;
  logic [WORD_BITS-1:0]      magic3;
  logic [pwks_pkg::RCP_W-1:0] rcp_tab [NMAX];
  logic [PROD_W-1:0]         prod;

  for (genvar g = 1; g <= NMAX; g++) begin : g_rcp
    localparam int Rcp = ((1 << pwks_pkg::RCP_SHIFT) + g - 1) / g;
    assign rcp_tab[g-1] = pwks_pkg::RCP_W'(Rcp);
  end

  always_comb begin
    lo_bit = '0;
    hi_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (magic_in[i]) begin
        lo_bit = BIT_W'(i);
      end
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      if (magic_in[i]) begin
        hi_bit = BIT_W'(i);
      end
    end
  end

  always_comb begin
    case (ctl_in.mode)
      pwks_pkg::MODE_LOW_TOP:    numer_next = TOP - lo_bit;
      pwks_pkg::MODE_HIGH_TOP:   numer_next = TOP - hi_bit;
      pwks_pkg::MODE_LOW_BOTTOM: numer_next = lo_bit;
      default:                   numer_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid3 <= ctl_in.valid;
      done   <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    mode3   <= ctl_in.mode;
    n_idx3  <= n_idx_in;
    numer   <= numer_next;
    found3  <= |magic_in;
    magic3  <= magic_in;
  end

  assign prod    = PROD_W'(numer) * PROD_W'(rcp_tab[n_idx3]);
  assign use_pos = found3 & (mode3 == pwks_pkg::MODE_LOW_TOP
                          || mode3 == pwks_pkg::MODE_HIGH_TOP
                          || mode3 == pwks_pkg::MODE_LOW_BOTTOM);

  always_ff @(posedge clk) begin
    magic         <= magic3;
    found         <= found3;
    slot_position <= use_pos ? prod[pwks_pkg::RCP_SHIFT +: pwks_pkg::POS_W] : '0;
  end

endmodule

/* rtl/core/packed_word_key_search.sv */
// top level of the packed word key search
//
// channel   | ports                                   | handshake
// request   | start, busy, bucket_word, search_key    | taken when start high, busy low
// result    | done, match_mask, found, slot_position  | valid for the one cycle done is high
// config    | cfg_write, cfg_index, cfg_data          | written when cfg_write high
//
// one request per cycle; each result appears after its request has passed
// four register stages: slot prep, subtract test,
// bit search, reciprocal multiply for the slot index
// busy is always low; the pipeline never stalls
// synchronous reset clears the valid bits and sets the config registers to their defaults
module packed_word_key_search #(
  parameter int WORD_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [pwks_pkg::BUS_BITS-1:0]       bucket_word,
  input  logic [pwks_pkg::KEY_W-1:0]          search_key,
  output logic                                done,
  output logic [pwks_pkg::BUS_BITS-1:0]       match_mask,
  output logic                                found,
  output logic [pwks_pkg::POS_W-1:0]          slot_position,
  input  logic                                cfg_write,
  input  logic [pwks_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pwks_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NMAX  = (WORD_BITS < pwks_pkg::MAX_KEY_BITS) ? WORD_BITS
                                                             : pwks_pkg::MAX_KEY_BITS;
  localparam int IDX_W = $clog2(NMAX);
  localparam int BIT_W = $clog2(WORD_BITS);

  logic [pwks_pkg::CFG_DATA_W-1:0] key_bits;
  logic                            pack_low;
  logic [pwks_pkg::MODE_W-1:0]     locate_mode;

  pwks_pkg::ctl_t       ctl1;
  pwks_pkg::ctl_t       ctl2;
  logic [IDX_W-1:0]     n_idx1;
  logic [IDX_W-1:0]     n_idx2;
  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] lsbs;
  logic [WORD_BITS-1:0] msbs;
  logic [WORD_BITS-1:0] magic2;
  logic [WORD_BITS-1:0] magic;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bits    <= pwks_pkg::CFG_DATA_W'(8);
      pack_low    <= 1'b0;
      locate_mode <= pwks_pkg::MODE_LOW_TOP;
    end else if (cfg_write) begin
      case (cfg_index)
        pwks_pkg::REG_KEY_BITS:    key_bits    <= cfg_data;
        pwks_pkg::REG_PACK_LOW:    pack_low    <= cfg_data[0];
        pwks_pkg::REG_LOCATE_MODE: locate_mode <= cfg_data[pwks_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pwks_slot_prep #(
    .WORD_BITS (WORD_BITS),
    .NMAX      (NMAX),
    .IDX_W     (IDX_W)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start & ~busy),
    .bucket      (bucket_word[WORD_BITS-1:0]),
    .search_key  (search_key),
    .key_bits    (key_bits),
    .pack_low    (pack_low),
    .locate_mode (locate_mode),
    .ctl         (ctl1),
    .n_idx       (n_idx1),
    .x           (x),
    .lsbs        (lsbs),
    .msbs        (msbs)
  );

  pwks_match #(
    .WORD_BITS (WORD_BITS),
    .IDX_W     (IDX_W)
  ) u_match (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl1),
    .n_idx_in (n_idx1),
    .x        (x),
    .lsbs     (lsbs),
    .msbs     (msbs),
    .ctl      (ctl2),
    .n_idx    (n_idx2),
    .magic    (magic2)
  );

  pwks_locate #(
    .WORD_BITS (WORD_BITS),
    .NMAX      (NMAX),
    .IDX_W     (IDX_W),
    .BIT_W     (BIT_W)
  ) u_locate (
    .clk           (clk),
    .rst           (rst),
    .ctl_in        (ctl2),
    .n_idx_in      (n_idx2),
    .magic_in      (magic2),
    .done          (done),
    .magic         (magic),
    .found         (found),
    .slot_position (slot_position)
  );

  assign match_mask = pwks_pkg::BUS_BITS'(magic);

endmodule
